// ===== src/unaligned_byte_lane_memory_access_unit_defines.svh =====
// assertion macros shared by the unaligned byte lane memory access unit
`ifndef UNALIGNED_BYTE_LANE_MEMORY_ACCESS_UNIT_DEFINES_SVH
`define UNALIGNED_BYTE_LANE_MEMORY_ACCESS_UNIT_DEFINES_SVH

// clocked property, disabled while reset is high
`define UBLMA_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// same-cycle implication
`define UBLMA_ASSERT_IMP(label, ante, cons, msg) \
   `UBLMA_ASSERT_CLK(label, (ante) |-> (cons), msg)

// next-cycle implication
`define UBLMA_ASSERT_NXT(label, ante, cons, msg) \
   `UBLMA_ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ===== src/ublma_pkg.sv =====
// shared types, codes and helpers of the unaligned byte lane memory access unit
package ublma_pkg;

   localparam int unsigned STORE_WORDS_DEFAULT = 512;

   // width for bank indexes before trimming to the bank depth
   localparam int unsigned ADDR_EXT_W = 17;
   // width for end-of-access byte offsets compared against the store size
   localparam int unsigned SPAN_W = 19;

   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;
   localparam logic [1:0] SIZE_NONE = 2'd3;

   typedef struct packed {
      logic capture;   // latch request and read both banks
      logic commit;    // merge, write back and send the response beat
   } ublma_cmd_type;

   // byte enables of an aligned access of the given size
   function automatic logic [3:0] size_byte_mask(input logic [1:0] size_code);
      logic [3:0] mask;
      unique case (size_code)
         SIZE_BYTE: mask = 4'b0001;
         SIZE_HALF: mask = 4'b0011;
         SIZE_WORD: mask = 4'b1111;
         default:   mask = 4'b0000;
      endcase
      return mask;
   endfunction

   // expand byte enables to bit enables
   function automatic logic [63:0] bytes_to_bits(input logic [7:0] byte_mask);
      logic [63:0] bits;
      for (int i = 0; i < 8; i++) begin
         bits[i*8 +: 8] = {8{byte_mask[i]}};
      end
      return bits;
   endfunction

endpackage

// ===== src/ublma_ctrl.sv =====
// controller state machine of the unaligned byte lane memory access unit
`include "unaligned_byte_lane_memory_access_unit_defines.svh"

module ublma_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output ublma_pkg::ublma_cmd_type cmd,
   output logic                    rsp_valid
);
   import ublma_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign busy   = (state_ff == ST_MERGE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_MERGE;
         ST_MERGE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign cmd.capture  = accept;
   assign cmd.commit   = (state_ff == ST_MERGE);
   assign rsp_valid_in = cmd.commit;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `UBLMA_ASSERT_NXT(a_accept_enters_merge, accept, state_ff == ST_MERGE,
                     "accepted beat did not enter merge")
   `UBLMA_ASSERT_NXT(a_merge_one_cycle, state_ff == ST_MERGE,
                     (state_ff == ST_IDLE) && rsp_valid_ff,
                     "merge did not finish with a response beat")
   `UBLMA_ASSERT_IMP(a_rsp_has_request, rsp_valid_ff, $past(accept, 2),
                     "response beat without a request two cycles earlier")

endmodule

// ===== src/ublma_datapath.sv =====
// banked word store, range check and byte lane merge datapath
module ublma_datapath #(
   parameter int unsigned STORE_WORDS = ublma_pkg::STORE_WORDS_DEFAULT
) (
   input  logic                     clock,
   input  ublma_pkg::ublma_cmd_type cmd,
   input  logic                     req_action,
   input  logic [1:0]               req_size_code,
   input  logic [10:0]              req_byte_address,
   input  logic [31:0]              req_write_data,
   output logic [31:0]              rsp_read_data,
   output logic                     rsp_range_error
);
   import ublma_pkg::*;

   localparam int unsigned BANK_WORDS = (STORE_WORDS + 1) / 2;
   localparam int unsigned BIDX_W     = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;
   localparam logic [SPAN_W-1:0] STORE_BYTES = SPAN_W'(STORE_WORDS * 4);

   // even words in one bank, odd words in the other: the two words of a
   // misaligned access always sit in different banks
   logic [31:0] even_mem [BANK_WORDS];
   logic [31:0] odd_mem  [BANK_WORDS];

   logic              act_ff, act_in;
   logic [1:0]        size_ff, size_in;
   logic [1:0]        lane_ff, lane_in;
   logic              odd_lo_ff, odd_lo_in;
   logic              err_ff, err_in;
   logic [31:0]       wdata_ff, wdata_in;
   logic [BIDX_W-1:0] even_idx_ff, even_idx_in;
   logic [BIDX_W-1:0] odd_idx_ff, odd_idx_in;
   logic [31:0]       even_rd_ff, odd_rd_ff;
   logic [31:0]       read_data_ff, read_data_in;
   logic              range_error_ff, range_error_in;

   logic [8:0]            even_sum;
   logic [ADDR_EXT_W-1:0] even_ext, odd_ext;
   logic [SPAN_W-1:0]     span_end;

   logic [31:0] lo_word, hi_word;
   logic [63:0] joined, data64, bit_mask64, merged;
   logic [4:0]  shift;
   logic [7:0]  byte_mask8;
   logic [63:0] size_bits;
   logic [31:0] read_val;
   logic        do_write, lo_en, hi_en, wr_even, wr_odd;
   logic [31:0] even_wdata, odd_wdata;

   // request side
   assign even_sum = {1'b0, req_byte_address[10:3]} + {8'b0, req_byte_address[2]};
   assign even_ext = ADDR_EXT_W'(even_sum);
   assign odd_ext  = ADDR_EXT_W'(req_byte_address[10:3]);

   assign span_end = SPAN_W'(req_byte_address) + (SPAN_W'(1) << req_size_code);

   assign act_in      = req_action;
   assign size_in     = req_size_code;
   assign lane_in     = req_byte_address[1:0];
   assign odd_lo_in   = req_byte_address[2];
   assign err_in      = (req_size_code != SIZE_NONE) && (span_end > STORE_BYTES);
   assign wdata_in    = req_write_data;
   assign even_idx_in = even_ext[BIDX_W-1:0];
   assign odd_idx_in  = odd_ext[BIDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff      <= act_in;
         size_ff     <= size_in;
         lane_ff     <= lane_in;
         odd_lo_ff   <= odd_lo_in;
         err_ff      <= err_in;
         wdata_ff    <= wdata_in;
         even_idx_ff <= even_idx_in;
         odd_idx_ff  <= odd_idx_in;
      end
   end

   // merge side
   assign lo_word    = odd_lo_ff ? odd_rd_ff : even_rd_ff;
   assign hi_word    = odd_lo_ff ? even_rd_ff : odd_rd_ff;
   assign joined     = {hi_word, lo_word};
   assign shift      = {lane_ff, 3'b000};
   assign byte_mask8 = {4'b0000, size_byte_mask(size_ff)} << lane_ff;
   assign bit_mask64 = bytes_to_bits(byte_mask8);
   assign size_bits  = bytes_to_bits({4'b0000, size_byte_mask(size_ff)});
   assign data64     = {32'b0, wdata_ff} << shift;
   assign merged     = (joined & ~bit_mask64) | (data64 & bit_mask64);
   assign read_val   = 32'(joined >> shift) & size_bits[31:0];

   assign do_write = cmd.commit && (act_ff == ACTION_WRITE) && !err_ff;
   assign lo_en    = do_write && (|byte_mask8[3:0]);
   assign hi_en    = do_write && (|byte_mask8[7:4]);

   assign wr_even    = odd_lo_ff ? hi_en : lo_en;
   assign wr_odd     = odd_lo_ff ? lo_en : hi_en;
   assign even_wdata = odd_lo_ff ? merged[63:32] : merged[31:0];
   assign odd_wdata  = odd_lo_ff ? merged[31:0] : merged[63:32];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         even_rd_ff <= even_mem[even_idx_in];
      end
      if (wr_even) begin
         even_mem[even_idx_ff] <= even_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         odd_rd_ff <= odd_mem[odd_idx_in];
      end
      if (wr_odd) begin
         odd_mem[odd_idx_ff] <= odd_wdata;
      end
   end

   assign read_data_in   = ((act_ff == ACTION_READ) && !err_ff) ? read_val : 32'b0;
   assign range_error_in = err_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         read_data_ff   <= read_data_in;
         range_error_ff <= range_error_in;
      end
   end

   assign rsp_read_data   = read_data_ff;
   assign rsp_range_error = range_error_ff;

endmodule

// ===== src/unaligned_byte_lane_memory_access_unit.sv =====
// top level of the unaligned byte lane memory access unit
//
//   channel   ports                                   handshake
//   request   req_action req_size_code                start high, busy low
//             req_byte_address req_write_data
//   response  rsp_read_data rsp_range_error           rsp_valid, one cycle
//
// a request beat is accepted in the idle state, which reads both neighboring
// aligned words (one from the even bank, one from the odd bank); the merge
// state then merges byte lanes, writes back and registers the response beat
// busy is high in the merge state, so a new beat is not accepted until the
// merge is done; it can be accepted in the same cycle the response is shown
// reset clears the controller only; the word store has no reset
// the response beat stands for exactly one cycle and cannot be stalled
module unaligned_byte_lane_memory_access_unit #(
   parameter int unsigned STORE_WORDS = ublma_pkg::STORE_WORDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [1:0]  req_size_code,
   input  logic [10:0] req_byte_address,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic        rsp_range_error
);
   import ublma_pkg::*;

   // capture and commit strobes from controller to datapath
   ublma_cmd_type cmd;

   ublma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // banks, range check, lane merge and response registers
   ublma_datapath #(
      .STORE_WORDS (STORE_WORDS)
   ) u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .req_action       (req_action),
      .req_size_code    (req_size_code),
      .req_byte_address (req_byte_address),
      .req_write_data   (req_write_data),
      .rsp_read_data    (rsp_read_data),
      .rsp_range_error  (rsp_range_error)
   );

endmodule

// ===== dv/unaligned_byte_lane_memory_access_unit_test.sv =====
// self-checking testbench of the unaligned byte lane memory access unit
`timescale 1ns / 1ps

module unaligned_byte_lane_memory_access_unit_test;
   import ublma_pkg::*;

   localparam int unsigned STORE_WORDS = STORE_WORDS_DEFAULT;
   localparam int unsigned STORE_BYTES = STORE_WORDS * 4;
   localparam int unsigned RANDOM_BEATS = 1100;

   // one request beat as the driver presents it
   typedef struct {
      logic        action;
      logic [1:0]  size_code;
      logic [10:0] byte_address;
      logic [31:0] write_data;
   } mem_access_type;

   // one response beat as the block should show it
   typedef struct {
      logic [31:0] read_data;
      logic        range_error;
   } mem_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = ACTION_READ;
   logic [1:0]  req_size_code = SIZE_BYTE;
   logic [10:0] req_byte_address = '0;
   logic [31:0] req_write_data = '0;
   logic        rsp_valid;
   logic [31:0] rsp_read_data;
   logic        rsp_range_error;

   unaligned_byte_lane_memory_access_unit #(
      .STORE_WORDS(STORE_WORDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_size_code(req_size_code),
      .req_byte_address(req_byte_address),
      .req_write_data(req_write_data),
      .rsp_valid(rsp_valid),
      .rsp_read_data(rsp_read_data),
      .rsp_range_error(rsp_range_error)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stimulus side: beats waiting to go out and the map of bytes they will have written
   mem_access_type pending_q[$];
   bit             byte_written[STORE_BYTES];
   int unsigned    written_starts[$];

   // prediction side: our own image of the word store and the responses it implies
   logic [31:0]    word_image[STORE_WORDS];
   mem_reply_type  expected_replies[$];

   mem_access_type current_access;
   int unsigned idle_cycles = 0;
   bit          steady_run = 1'b0;
   int unsigned beats_sent = 0;
   int unsigned replies_checked = 0;
   int unsigned error_count = 0;
   int unsigned reads_seen = 0, writes_seen = 0, range_seen = 0;
   int unsigned unused_seen = 0, split_seen = 0;

   // queue a beat and remember which bytes it leaves defined
   task automatic plan(input logic action, input logic [1:0] size_code,
                       input int unsigned byte_address, input logic [31:0] write_data);
      mem_access_type a;
      a.action       = action;
      a.size_code    = size_code;
      a.byte_address = byte_address[10:0];
      a.write_data   = write_data;
      pending_q.push_back(a);
      if (action == ACTION_WRITE && size_code != SIZE_NONE &&
          byte_address + (1 << size_code) <= STORE_BYTES) begin
         for (int k = 0; k < (1 << size_code); k++) byte_written[byte_address + k] = 1'b1;
         written_starts.push_back(byte_address);
      end
   endtask

   // true when every byte of the access is inside the store and already written
   function automatic bit readable(input logic [1:0] size_code, input int unsigned byte_address);
      if (byte_address + (1 << size_code) > STORE_BYTES) return 1'b0;
      for (int k = 0; k < (1 << size_code); k++)
         if (!byte_written[byte_address + k]) return 1'b0;
      return 1'b1;
   endfunction

   // one or two random beats; in-range reads of a used size land only on bytes that were written before
   task automatic plan_random_access();
      int unsigned pick, addr, base, tries;
      logic [1:0]  sz;
      bit          found;
      pick = $urandom_range(0, 99);
      sz   = 2'($urandom_range(SIZE_BYTE, SIZE_WORD));
      if (pick < 4) begin
         // unused size code, anywhere
         plan(1'($urandom_range(0, 1)), SIZE_NONE, $urandom_range(0, STORE_BYTES - 1),
              $urandom);
      end else if (pick < 10) begin
         // runs past the last byte of the store
         sz   = 2'($urandom_range(SIZE_HALF, SIZE_WORD));
         addr = STORE_BYTES - $urandom_range(1, (1 << sz) - 1);
         plan(1'($urandom_range(0, 1)), sz, addr, $urandom);
      end else if (pick < 55 || written_starts.size() == 0) begin
         addr = $urandom_range(0, STORE_BYTES - (1 << sz));
         plan(ACTION_WRITE, sz, addr, $urandom);
         // write then read back, often narrower than the write
         if ($urandom_range(0, 3) == 0)
            plan(ACTION_READ, 2'($urandom_range(SIZE_BYTE, sz)), addr, $urandom);
      end else begin
         found = 1'b0;
         base  = 0;
         addr  = 0;
         for (tries = 0; tries < 8 && !found; tries++) begin
            base = written_starts[$urandom_range(0, written_starts.size() - 1)];
            addr = base + $urandom_range(0, 6);
            addr = (addr >= 3) ? addr - 3 : 0;
            if (readable(sz, addr)) found = 1'b1;
            else sz = 2'($urandom_range(SIZE_BYTE, SIZE_WORD));
         end
         // the first byte of any earlier write is always safe to read
         if (found) plan(ACTION_READ, sz, addr, $urandom);
         else plan(ACTION_READ, SIZE_BYTE, base, $urandom);
      end
   endtask

   // what the block does to its store for one beat, and what it answers
   function automatic mem_reply_type apply_access(input mem_access_type a);
      mem_reply_type r;
      int unsigned   nbytes, lane_addr;
      r.read_data   = '0;
      r.range_error = 1'b0;
      if (a.size_code == SIZE_NONE) begin
         unused_seen++;
         return r;
      end
      nbytes = 1 << a.size_code;
      if (a.byte_address + nbytes > STORE_BYTES) begin
         range_seen++;
         r.range_error = 1'b1;
         return r;
      end
      if ((a.byte_address % 4) + nbytes > 4) split_seen++;
      if (a.action == ACTION_WRITE) writes_seen++;
      else reads_seen++;
      for (int k = 0; k < nbytes; k++) begin
         lane_addr = a.byte_address + k;
         if (a.action == ACTION_WRITE)
            word_image[lane_addr >> 2][(lane_addr % 4) * 8 +: 8] = a.write_data[k * 8 +: 8];
         else
            r.read_data[k * 8 +: 8] = word_image[lane_addr >> 2][(lane_addr % 4) * 8 +: 8];
      end
      return r;
   endfunction

   // idle length between request beats: mostly short, a few long, none in steady runs
   function automatic int unsigned next_gap();
      int unsigned r;
      if (steady_run) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic present_next();
      current_access   = pending_q.pop_front();
      req_action       <= current_access.action;
      req_size_code    <= current_access.size_code;
      req_byte_address <= current_access.byte_address;
      req_write_data   <= current_access.write_data;
      start            <= 1'b1;
   endtask

   // request driver: a beat moves on an edge with start high and busy low
   always @(posedge clock) begin : request_driver
      int unsigned gap;
      if (reset) begin
         start       <= 1'b0;
         idle_cycles <= 0;
      end else if (start && !busy) begin
         // beat accepted here, so predict its response now
         expected_replies.push_back(apply_access(current_access));
         beats_sent++;
         // switch between gappy and back-to-back stretches now and then
         if (beats_sent % 64 == 0) steady_run = ($urandom_range(0, 3) == 0);
         gap = next_gap();
         // with no gap, start stays high and the next beat waits out busy
         if (gap == 0 && pending_q.size() != 0) present_next();
         else begin
            start       <= 1'b0;
            idle_cycles <= gap;
         end
      end else if (!start) begin
         if (idle_cycles != 0) idle_cycles <= idle_cycles - 1;
         else if (pending_q.size() != 0) present_next();
      end
   end

   // response monitor: every strobed beat must match the oldest prediction
   always @(posedge clock) begin : response_monitor
      mem_reply_type want;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            $error("response beat with no request outstanding");
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            replies_checked++;
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %h, actual %h", want.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_range_error !== want.range_error) begin
               $error("range_error: expected %b, actual %b", want.range_error,
                      rsp_range_error);
               error_count++;
            end
         end
      end
   end

   initial begin
      // directed: full word, lane merge, misaligned spans, both ends of the store
      plan(ACTION_WRITE, SIZE_WORD, 0, 32'hFFFF_FFFF);
      plan(ACTION_READ,  SIZE_WORD, 0, 32'h0);
      plan(ACTION_WRITE, SIZE_BYTE, 1, 32'hAAAA_AA00);
      plan(ACTION_READ,  SIZE_WORD, 0, 32'hFFFF_FFFF);
      plan(ACTION_WRITE, SIZE_HALF, 3, 32'hBBBB_1234);
      plan(ACTION_READ,  SIZE_HALF, 3, 32'h0);
      plan(ACTION_READ,  SIZE_BYTE, 4, 32'h0);
      plan(ACTION_WRITE, SIZE_WORD, STORE_BYTES - 4, 32'h8000_0001);
      plan(ACTION_READ,  SIZE_BYTE, STORE_BYTES - 1, 32'h0);
      plan(ACTION_READ,  SIZE_HALF, STORE_BYTES - 2, 32'h0);
      plan(ACTION_READ,  SIZE_WORD, STORE_BYTES - 4, 32'h0);
      // past the end: flagged and nothing changes, then a byte write to the last byte that fits
      plan(ACTION_WRITE, SIZE_WORD, STORE_BYTES - 3, 32'h0000_0000);
      plan(ACTION_WRITE, SIZE_HALF, STORE_BYTES - 1, 32'h0000_0000);
      plan(ACTION_READ,  SIZE_WORD, STORE_BYTES - 1, 32'h0);
      plan(ACTION_READ,  SIZE_HALF, STORE_BYTES - 1, 32'h0);
      plan(ACTION_WRITE, SIZE_BYTE, STORE_BYTES - 1, 32'h1234_5678);
      // unused size code does nothing at all
      plan(ACTION_WRITE, SIZE_NONE, STORE_BYTES - 4, 32'h0);
      plan(ACTION_READ,  SIZE_NONE, 0, 32'hFFFF_FFFF);
      plan(ACTION_READ,  SIZE_WORD, STORE_BYTES - 4, 32'h0);
      // words straddling an aligned boundary
      plan(ACTION_WRITE, SIZE_WORD, 1025, 32'hDEAD_BEEF);
      plan(ACTION_READ,  SIZE_WORD, 1025, 32'h0);
      plan(ACTION_READ,  SIZE_HALF, 1027, 32'h0);
      plan(ACTION_READ,  SIZE_BYTE, 1028, 32'h0);
      plan(ACTION_WRITE, SIZE_HALF, 1023, 32'h0000_A55A);
      plan(ACTION_READ,  SIZE_WORD, 1023, 32'h0);

      repeat (RANDOM_BEATS) plan_random_access();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // drain: all beats out and every response back
      while (pending_q.size() != 0 || start || expected_replies.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("beats: %0d (%0d reads, %0d writes, %0d past the end, %0d unused size)",
               beats_sent, reads_seen, writes_seen, range_seen, unused_seen);
      $display("%0d accesses split across two words, %0d responses checked",
               split_seen, replies_checked);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/ublma_pkg.sv
src/ublma_ctrl.sv
src/ublma_datapath.sv
src/unaligned_byte_lane_memory_access_unit.sv
dv/unaligned_byte_lane_memory_access_unit_test.sv
